### hw/rtl/assert_macros.svh
// Assertion macros used by the port checker.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked at every edge, reset included
`define SCA_ASSERT(label, prop, msg) label: assert property (@(posedge clk) prop) \
  else $error(msg);
// checked only while out of reset
`define SCA_ASSERT_RST(label, prop, msg) label: assert property ( \
  @(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

### hw/rtl/sca_pkg.sv
// Shared constants, beat types and helpers for soft_clamp_angle.
// No dependencies.
package sca_pkg;

  localparam int NCELL        = 32;              // cells per divider / root chain
  localparam int UNIT_STAGES  = 2 * NCELL + 8;   // registers in one limit unit
  localparam int ITEM_LATENCY = 2 * UNIT_STAGES + 2;

  localparam logic [31:0] T_Q32    = 32'h6A09E668;   // tan 22.5
  localparam logic [31:0] K_Q32    = 32'h4AFB0CCC;   // 1 - sin 45
  localparam logic [31:0] SQ2_FRAC = 32'h6A09E668;   // sqrt2 - 1
  localparam logic [33:0] TPS_Q32  = 34'h36A09E668;  // 2 + sqrt2

  typedef enum logic [1:0] {
    REG_MIN_ANGLE = 2'd0,
    REG_MIN_SOFT  = 2'd1,
    REG_MAX_ANGLE = 2'd2,
    REG_MAX_SOFT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               knee;
    logic signed [32:0] early;
  } side_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic        neg;
  } div_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] rad;
    logic [31:0] root;
    logic        zero;
  } sqrt_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > $signed(36'h07FFFFFFF)) return 32'h7FFFFFFF;
    if (x < $signed(36'hF80000000)) return 32'h80000000;
    return x[31:0];
  endfunction

endpackage

### hw/rtl/sca_div_cell.sv
// One restoring-division cell: one quotient bit per beat.
// Depends on sca_pkg.
module sca_div_cell import sca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] s,
  input  logic        vld_i,
  input  side_t       side_i,
  input  div_t        d_i,
  output logic        vld_o,
  output side_t       side_o,
  output div_t        d_o
);

  logic        vld_r;
  side_t       side_r;
  div_t        d_r, d_nxt;
  logic [31:0] t;

  always_comb begin
    t = {d_i.rem, d_i.low[31]};
    d_nxt = d_i;
    d_nxt.low = {d_i.low[30:0], 1'b0};
    if (t >= {1'b0, s}) begin
      d_nxt.rem = 31'(t - {1'b0, s});
      d_nxt.quo = {d_i.quo[30:0], 1'b1};
    end else begin
      d_nxt.rem = t[30:0];
      d_nxt.quo = {d_i.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    d_r    <= d_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign d_o    = d_r;

endmodule

### hw/rtl/sca_sqrt_cell.sv
// One digit-recurrence square-root cell: one root bit per beat.
// Depends on sca_pkg.
module sca_sqrt_cell import sca_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  side_t side_i,
  input  sqrt_t q_i,
  output logic  vld_o,
  output side_t side_o,
  output sqrt_t q_o
);

  logic        vld_r;
  side_t       side_r;
  sqrt_t       q_r, q_nxt;
  logic [35:0] r2, trial;

  always_comb begin
    r2    = {q_i.rem, q_i.rad[31:30]};
    trial = {2'b00, q_i.root, 2'b01};
    q_nxt = q_i;
    q_nxt.rad = {q_i.rad[29:0], 2'b00};
    if (r2 >= trial) begin
      q_nxt.rem  = 34'(r2 - trial);
      q_nxt.root = {q_i.root[30:0], 1'b1};
    end else begin
      q_nxt.rem  = r2[33:0];
      q_nxt.root = {q_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    q_r    <= q_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign q_o    = q_r;

endmodule

### hw/rtl/sca_limit.sv
// Soft upper limit: knee test, divider chain, root chain, offset multiply.
// Depends on sca_pkg, sca_div_cell, sca_sqrt_cell.
module sca_limit import sca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [30:0]        s,
  input  logic signed [32:0] m,
  input  logic               in_vld,
  input  logic signed [32:0] v,
  output logic               res_vld,
  output logic signed [34:0] res
);

  logic [31:0] h_r;

  always_ff @(posedge clk) begin
    h_r <= {1'b0, s} + 32'((62'(s) * 62'(SQ2_FRAC) + 62'h80000000) >> 32);
  end

  // knee decision
  logic signed [34:0] mx, vx, lo_b, hi_b, a;
  side_t              dec_side;

  always_comb begin
    mx   = 35'(m);
    vx   = 35'(v);
    lo_b = mx - $signed({4'b0000, s});
    hi_b = mx + $signed({3'b000, h_r});
    a    = mx - vx;
    dec_side.knee  = 1'b0;
    dec_side.early = v;
    if (s == '0) begin
      if (v > m) dec_side.early = m;
    end else if (vx < lo_b) begin
      dec_side.early = v;
    end else if (vx > hi_b) begin
      dec_side.early = m;
    end else begin
      dec_side.knee = 1'b1;
    end
  end

  logic        d_vld_r, m_vld_r;
  side_t       d_side_r, m_side_r;
  logic [31:0] d_mag_r;
  logic        d_neg_r, m_neg_r;
  logic [62:0] m_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
    end else begin
      d_vld_r <= in_vld;
      m_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_side_r <= dec_side;
    d_neg_r  <= a[34];
    d_mag_r  <= a[34] ? 32'(-a) : 32'(a);
    m_side_r <= d_side_r;
    m_neg_r  <= d_neg_r;
    m_prod_r <= 63'(d_mag_r) * 63'(K_Q32);
  end

  // divider chain: |a|*K / s
  logic  dv [0:NCELL];
  side_t ds [0:NCELL];
  div_t  dd [0:NCELL];

  assign dv[0] = m_vld_r;
  assign ds[0] = m_side_r;
  assign dd[0] = '{rem: m_prod_r[62:32], low: m_prod_r[31:0], quo: '0, neg: m_neg_r};

  for (genvar i = 0; i < NCELL; i++) begin : g_div
    sca_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .s(s),
      .vld_i(dv[i]), .side_i(ds[i]), .d_i(dd[i]),
      .vld_o(dv[i+1]), .side_o(ds[i+1]), .d_o(dd[i+1])
    );
  end

  // knee coordinate u, then radicand 1 - u^2
  logic signed [33:0] us;
  logic               u_vld_r, w_vld_r;
  side_t              u_side_r, w_side_r;
  logic [31:0]        u_r, u2;
  logic [63:0]        usq;
  sqrt_t              w_q_r;

  always_comb begin
    if (dd[NCELL].neg) us = $signed({2'b00, T_Q32}) - $signed({2'b00, dd[NCELL].quo});
    else               us = $signed({2'b00, T_Q32}) + $signed({2'b00, dd[NCELL].quo});
    usq = 64'(u_r) * 64'(u_r);
    u2  = usq[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
    end else begin
      u_vld_r <= dv[NCELL];
      w_vld_r <= u_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    u_side_r <= ds[NCELL];
    if (us[33])                  u_r <= '0;
    else if (us[32])             u_r <= 32'hFFFFFFFF;
    else                         u_r <= us[31:0];
    w_side_r   <= u_side_r;
    w_q_r.rem  <= '0;
    w_q_r.root <= '0;
    w_q_r.rad  <= 32'(33'h100000000 - {1'b0, u2});
    w_q_r.zero <= (u2 == '0);
  end

  // root chain
  logic  qv [0:NCELL];
  side_t qs [0:NCELL];
  sqrt_t qq [0:NCELL];

  assign qv[0] = w_vld_r;
  assign qs[0] = w_side_r;
  assign qq[0] = w_q_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_sqrt
    sca_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(qv[i]), .side_i(qs[i]), .q_i(qq[i]),
      .vld_o(qv[i+1]), .side_o(qs[i+1]), .q_o(qq[i+1])
    );
  end

  // offset = round(s * (1 - root) * (2 + sqrt2))
  logic [32:0] fk;
  logic [97:0] sum;
  logic        f_vld_r, g_vld_r, r_vld_r, o_vld_r;
  side_t       f_side_r, g_side_r, r_side_r;
  logic [63:0] f_prod_r;
  logic [65:0] g_hi_r, g_lo_r;
  logic [32:0] r_off_r;
  logic signed [34:0] res_r;

  always_comb begin
    fk  = qq[NCELL].zero ? 33'd0 : 33'h100000000 - {1'b0, qq[NCELL].root};
    sum = {g_hi_r, 32'h0} + 98'(g_lo_r) + (98'd1 << 63);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      f_vld_r <= qv[NCELL];
      g_vld_r <= f_vld_r;
      r_vld_r <= g_vld_r;
      o_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f_side_r <= qs[NCELL];
    f_prod_r <= 64'(s) * 64'(fk);
    g_side_r <= f_side_r;
    g_hi_r   <= 66'(f_prod_r[63:32]) * 66'(TPS_Q32);
    g_lo_r   <= 66'(f_prod_r[31:0]) * 66'(TPS_Q32);
    r_side_r <= g_side_r;
    r_off_r  <= sum[96:64];
    if (r_side_r.knee) res_r <= 35'(m) - $signed({2'b00, r_off_r});
    else               res_r <= 35'(r_side_r.early);
  end

  assign res_vld = o_vld_r;
  assign res     = res_r;

endmodule

### hw/rtl/soft_clamp_angle.sv
// Top level of the soft angle clamp: register file, two limit units, I/O.
// Depends on sca_pkg and sca_limit.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | start, busy, in_input_angle             | beat taken when start & !busy
//  result  | out_valid, out_output_angle             | one-cycle strobe, no stall
//  config  | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// One beat per cycle, back to back, while busy is low; busy is high during reset and in the cycle after it.
// From the accepting edge to out_valid a beat passes through the
//   input register, lower limit unit (72 stages), saturation register,
//   upper limit unit (72 stages) and output register.
// Each limit unit's depth is set by its 32-cell divider chain and its
//   32-cell square-root chain, one bit per cell.
// Reset (synchronous, rst_n low) clears the config registers to zero, sets busy
//   and drops all in-flight beats; the result side cannot stall, so nothing backs up.
module soft_clamp_angle import sca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_input_angle,
  output logic               out_valid,
  output logic signed [31:0] out_output_angle,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register file
  logic signed [31:0] min_angle_r, max_angle_r;
  logic [30:0]        min_soft_r, max_soft_r;
  reg_idx_t           idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_angle_r <= '0;
      min_soft_r  <= '0;
      max_angle_r <= '0;
      max_soft_r  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_MIN_ANGLE: min_angle_r <= pwdata;
        REG_MIN_SOFT:  min_soft_r  <= pwdata[30:0];
        REG_MAX_ANGLE: max_angle_r <= pwdata;
        REG_MAX_SOFT:  max_soft_r  <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_ANGLE: prdata = min_angle_r;
      REG_MIN_SOFT:  prdata = {1'b0, min_soft_r};
      REG_MAX_ANGLE: prdata = max_angle_r;
      REG_MAX_SOFT:  prdata = {1'b0, max_soft_r};
    endcase
  end

  // limits swap roles when max < min
  logic               swap;
  logic signed [31:0] lo_m, hi_m;
  logic [30:0]        lo_s, hi_s;

  always_comb begin
    swap = max_angle_r < min_angle_r;
    lo_m = swap ? max_angle_r : min_angle_r;
    lo_s = swap ? max_soft_r  : min_soft_r;
    hi_m = swap ? min_angle_r : max_angle_r;
    hi_s = swap ? min_soft_r  : max_soft_r;
  end

  // input beat
  logic               busy_r, in_vld_r;
  logic signed [31:0] in_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) in_ang_r <= in_input_angle;
  end

  assign busy = busy_r;

  // lower limit, worked as a mirrored upper limit
  logic               lo_vld;
  logic signed [34:0] lo_res;

  sca_limit u_lower (
    .clk(clk), .rst_n(rst_n),
    .s(lo_s), .m(-(33'(lo_m))),
    .in_vld(in_vld_r), .v(-(33'(in_ang_r))),
    .res_vld(lo_vld), .res(lo_res)
  );

  logic               mid_vld_r;
  logic signed [31:0] mid_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mid_vld_r <= 1'b0;
    else        mid_vld_r <= lo_vld;
  end

  always_ff @(posedge clk) begin
    mid_ang_r <= sat32(-(36'(lo_res)));
  end

  // upper limit
  logic               hi_vld;
  logic signed [34:0] hi_res;

  sca_limit u_upper (
    .clk(clk), .rst_n(rst_n),
    .s(hi_s), .m(33'(hi_m)),
    .in_vld(mid_vld_r), .v(33'(mid_ang_r)),
    .res_vld(hi_vld), .res(hi_res)
  );

  logic               out_vld_r;
  logic signed [31:0] out_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= hi_vld;
  end

  always_ff @(posedge clk) begin
    out_ang_r <= sat32(36'(hi_res));
  end

  assign out_valid        = out_vld_r;
  assign out_output_angle = out_ang_r;

endmodule

### hw/rtl/sca_checker.sv
// Port-level checks for soft_clamp_angle, bound to the top level.
// Depends on sca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sca_port_checker import sca_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  logic in_beat;

  assign in_beat = start && !busy;

  // reset drops every beat in flight
  `SCA_ASSERT(a_rst_drops_out, !rst_n |=> !out_valid, "result strobe after reset")
  // no beat is taken right after reset
  `SCA_ASSERT(a_rst_busy, !rst_n |=> busy, "busy low right after reset")
  // each accepted beat gives a result at fixed latency
  `SCA_ASSERT_RST(a_beat_out, $past(in_beat, ITEM_LATENCY + 1) |-> out_valid, "missing result")
  // no result without an accepted beat
  `SCA_ASSERT_RST(a_out_beat, out_valid |-> $past(in_beat, ITEM_LATENCY + 1), "stray result")

endmodule

bind soft_clamp_angle sca_port_checker u_sca_checker (.*);
